// ===== design/frt_pkg.sv =====
// shared types, codes and constants for the fragment reassembly tracker
package frt_pkg;

    // default bitmap size, handed to the top level parameter
    localparam int MAX_FRAGMENTS_DEF = 256;

    // full-size fragment payload in bytes
    localparam int PAYLOAD_BYTES = 1024;

    // field widths of the words
    localparam int TYPE_W  = 2;
    localparam int IP_W    = 32;
    localparam int PORT_W  = 16;
    localparam int MID_W   = 16;
    localparam int IDX_W   = 16;
    localparam int LEN_W   = 11;
    localparam int BYTES_W = 19;

    // bitmap memory row layout
    localparam int ROW_BITS  = 32;
    localparam int ROW_SEL_W = $clog2(ROW_BITS);

    // payload cap at field width
    localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(PAYLOAD_BYTES);

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_PROMISC   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PEER_IP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PEER_PORT = 2'd2;

    // packet types
    typedef enum logic [TYPE_W-1:0] {
        REQ_DATA   = 2'd0,
        REQ_ACK    = 2'd1,
        REQ_CHADDR = 2'd2,
        REQ_OTHER  = 2'd3
    } req_t;

    // result actions
    typedef enum logic [2:0] {
        ACT_DROP     = 3'd0,
        ACT_ACK      = 3'd1,
        ACT_FORWARD  = 3'd2,
        ACT_BAD_TYPE = 3'd3,
        ACT_SHORT    = 3'd4,
        ACT_RANGE    = 3'd5
    } action_t;

    // one received packet header
    typedef struct packed {
        req_t              req_type;
        logic [IP_W-1:0]   src_ip;
        logic [PORT_W-1:0] src_port;
        logic [MID_W-1:0]  message_id;
        logic [IDX_W-1:0]  fragment_index;
        logic [IDX_W-1:0]  fragment_total;
        logic [LEN_W-1:0]  pay_len;
    } in_t;

    // one result
    typedef struct packed {
        action_t            action;
        logic [IDX_W-1:0]   ack_index;
        logic               message_done;
        logic [MID_W-1:0]   done_message_id;
        logic [BYTES_W-1:0] message_bytes;
    } out_t;

    // bitmap write command from the tracker to the memory
    typedef struct packed {
        logic wr;
        logic clr;
    } bm_cmd_t;

endpackage

// ===== design/fragment_reassembly_tracker.sv =====
// top level of the fragment reassembly tracker: config, handshakes, output register
//
//   channel  direction  handshake            payload
//   s_       in         s_valid / s_ready    s_data  (in_t, one packet header)
//   m_       out        m_valid / m_ready    m_data  (out_t, one result)
//   cfg_     in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// one header per cycle sustained while m_ready keeps the output free; m_valid rises once the header
// has passed stage one (bitmap row read at the accepting edge, then update and output register)
// the bitmap row read is registered; a write to the row being read
// at the same edge is forwarded
// synchronous active-low reset; the bitmap rows are cleared by row valid bits
// a stalled output holds stage one, and s_ready follows once stage one is full
module fragment_reassembly_tracker #(
    parameter int MAX_FRAGMENTS = frt_pkg::MAX_FRAGMENTS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  frt_pkg::in_t                    s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output frt_pkg::out_t                   m_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [frt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [frt_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import frt_pkg::*;

    localparam int NUM_ROWS = (MAX_FRAGMENTS + ROW_BITS - 1) / ROW_BITS;
    localparam int ROWS     = (NUM_ROWS < 2) ? 2 : NUM_ROWS;
    localparam int ROW_AW   = $clog2(ROWS);

    logic                promisc_reg;
    logic [IP_W-1:0]     peer_ip_cfg_reg;
    logic [PORT_W-1:0]   peer_port_cfg_reg;
    logic                m_valid_reg;
    out_t                m_data_reg;
    logic                s1_valid;
    logic                out_free;
    logic                acc;
    logic                adv;
    out_t                result;
    bm_cmd_t             bm_cmd;
    logic [ROW_AW-1:0]   wr_row;
    logic [ROW_BITS-1:0] wr_data;
    logic [ROW_BITS-1:0] row_q;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            promisc_reg       <= 1'b0;
            peer_ip_cfg_reg   <= '0;
            peer_port_cfg_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_PROMISC:   promisc_reg       <= cfg_data[0];
                CFG_PEER_IP:   peer_ip_cfg_reg   <= cfg_data[IP_W-1:0];
                CFG_PEER_PORT: peer_port_cfg_reg <= cfg_data[PORT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // handshake control
    assign out_free = !m_valid_reg || m_ready;
    assign adv      = s1_valid && out_free;
    assign s_ready  = !s1_valid || out_free;
    assign acc      = s_valid && s_ready;

    frt_bitmap #(
        .MAX_FRAGMENTS (MAX_FRAGMENTS)
    ) u_bitmap (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (acc),
        .rd_row  (s_data.fragment_index[ROW_SEL_W +: ROW_AW]),
        .bm_cmd  (bm_cmd),
        .wr_row  (wr_row),
        .wr_data (wr_data),
        .row_q   (row_q)
    );

    frt_track #(
        .MAX_FRAGMENTS (MAX_FRAGMENTS)
    ) u_track (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .acc           (acc),
        .in_item       (s_data),
        .adv           (adv),
        .cfg_promisc   (promisc_reg),
        .cfg_peer_ip   (peer_ip_cfg_reg),
        .cfg_peer_port (peer_port_cfg_reg),
        .row_q         (row_q),
        .s1_valid      (s1_valid),
        .result        (result),
        .bm_cmd        (bm_cmd),
        .wr_row        (wr_row),
        .wr_data       (wr_data)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== design/frt_bitmap.sv =====
// fragment bitmap memory with row valid bits and write-to-read forwarding
module frt_bitmap #(
    parameter int MAX_FRAGMENTS = frt_pkg::MAX_FRAGMENTS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          rd_en,
    input  logic [$clog2((((MAX_FRAGMENTS + frt_pkg::ROW_BITS - 1) / frt_pkg::ROW_BITS) < 2)
                  ? 2 : ((MAX_FRAGMENTS + frt_pkg::ROW_BITS - 1) / frt_pkg::ROW_BITS))-1:0]
                                          rd_row,
    input  frt_pkg::bm_cmd_t              bm_cmd,
    input  logic [$clog2((((MAX_FRAGMENTS + frt_pkg::ROW_BITS - 1) / frt_pkg::ROW_BITS) < 2)
                  ? 2 : ((MAX_FRAGMENTS + frt_pkg::ROW_BITS - 1) / frt_pkg::ROW_BITS))-1:0]
                                          wr_row,
    input  logic [frt_pkg::ROW_BITS-1:0]  wr_data,
    output logic [frt_pkg::ROW_BITS-1:0]  row_q
);
    import frt_pkg::*;

    localparam int NUM_ROWS = (MAX_FRAGMENTS + ROW_BITS - 1) / ROW_BITS;
    localparam int ROWS     = (NUM_ROWS < 2) ? 2 : NUM_ROWS;
    localparam int ROW_AW   = $clog2(ROWS);

    logic [ROW_BITS-1:0] mem [ROWS];
    logic [ROW_BITS-1:0] rd_data_reg;
    logic [ROW_AW-1:0]   rd_row_reg;
    logic                fwd_hit_reg;
    logic                fwd_hit_next;
    logic [ROW_BITS-1:0] fwd_data_reg;
    logic [ROWS-1:0]     row_vld_reg;
    logic [ROWS-1:0]     row_vld_next;

    // memory write port and registered read port
    always_ff @(posedge aclk) begin
        if (bm_cmd.wr) begin
            mem[wr_row] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg  <= mem[rd_row];
            rd_row_reg   <= rd_row;
            fwd_data_reg <= wr_data;
        end
    end

    // a write landing on the row being read in the same cycle wins
    assign fwd_hit_next = bm_cmd.wr && (wr_row == rd_row);

    // row valid bits: a new message clears all rows at once
    always_comb begin
        row_vld_next = row_vld_reg;
        if (bm_cmd.wr) begin
            if (bm_cmd.clr) begin
                row_vld_next = '0;
            end
            row_vld_next = row_vld_next | (ROWS'(1) << wr_row);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_vld_reg <= '0;
            fwd_hit_reg <= 1'b0;
        end else begin
            row_vld_reg <= row_vld_next;
            if (rd_en) begin
                fwd_hit_reg <= fwd_hit_next;
            end
        end
    end

    // resolved row: forwarded, stored or cleared
    assign row_q = fwd_hit_reg ? fwd_data_reg :
                   (row_vld_reg[rd_row_reg] ? rd_data_reg : '0);

endmodule

// ===== design/frt_track.sv =====
// header register stage, peer filter and reassembly state update
module frt_track #(
    parameter int MAX_FRAGMENTS = frt_pkg::MAX_FRAGMENTS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          acc,
    input  frt_pkg::in_t                  in_item,
    input  logic                          adv,
    input  logic                          cfg_promisc,
    input  logic [frt_pkg::IP_W-1:0]      cfg_peer_ip,
    input  logic [frt_pkg::PORT_W-1:0]    cfg_peer_port,
    input  logic [frt_pkg::ROW_BITS-1:0]  row_q,
    output logic                          s1_valid,
    output frt_pkg::out_t                 result,
    output frt_pkg::bm_cmd_t              bm_cmd,
    output logic [$clog2((((MAX_FRAGMENTS + frt_pkg::ROW_BITS - 1) / frt_pkg::ROW_BITS) < 2)
                  ? 2 : ((MAX_FRAGMENTS + frt_pkg::ROW_BITS - 1) / frt_pkg::ROW_BITS))-1:0]
                                          wr_row,
    output logic [frt_pkg::ROW_BITS-1:0]  wr_data
);
    import frt_pkg::*;

    localparam int NUM_ROWS = (MAX_FRAGMENTS + ROW_BITS - 1) / ROW_BITS;
    localparam int ROWS     = (NUM_ROWS < 2) ? 2 : NUM_ROWS;
    localparam int ROW_AW   = $clog2(ROWS);
    localparam int CNT_W    = $clog2(MAX_FRAGMENTS + 1);
    localparam logic [IDX_W-1:0]   MAX_IDX   = IDX_W'(MAX_FRAGMENTS);
    localparam logic [BYTES_W-1:0] BYTES_MAX = '1;

    // stage one: the accepted header waiting for its bitmap row
    logic s1_valid_reg;
    in_t  s1_item_reg;

    // reassembly and peer state
    logic               receiving_reg,  receiving_next;
    logic [MID_W-1:0]   cur_msg_reg,    cur_msg_next;
    logic [CNT_W-1:0]   expected_reg,   expected_next;
    logic [CNT_W-1:0]   seen_reg,       seen_next;
    logic [BYTES_W-1:0] bytes_reg,      bytes_next;
    logic               peer_ovr_reg,   peer_ovr_next;
    logic [IP_W-1:0]    peer_ip_reg,    peer_ip_next;
    logic [PORT_W-1:0]  peer_port_reg,  peer_port_next;

    logic [LEN_W-1:0]    len_eff;
    logic                from_peer;
    logic [IDX_W-1:0]    idx;
    logic [IDX_W-1:0]    tot;
    logic [IDX_W-1:0]    exp16;
    logic [ROW_SEL_W-1:0] bit_sel;
    logic [ROW_BITS-1:0] bit_onehot;
    logic                seen_bit;
    logic [BYTES_W:0]    bytes_sum;
    logic [BYTES_W-1:0]  bytes_added;
    logic                start_range_bad;
    logic                start_short;
    logic                recv_range_bad;
    logic                recv_short;
    logic                wr_want;
    logic                clr_want;
    action_t             action;
    logic [IDX_W-1:0]    ack_index;
    logic                done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (acc) begin
            s1_valid_reg <= 1'b1;
        end else if (adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            s1_item_reg <= in_item;
        end
    end

    assign s1_valid = s1_valid_reg;

    // field decode and checks
    assign idx     = s1_item_reg.fragment_index;
    assign tot     = s1_item_reg.fragment_total;
    assign exp16   = IDX_W'(expected_reg);
    assign len_eff = (s1_item_reg.pay_len > LEN_CAP) ? LEN_CAP
                                                      : s1_item_reg.pay_len;

    assign from_peer = peer_ovr_reg ?
        ((s1_item_reg.src_ip == peer_ip_reg) && (s1_item_reg.src_port == peer_port_reg)) :
        ((s1_item_reg.src_ip == cfg_peer_ip) && (s1_item_reg.src_port == cfg_peer_port));

    assign start_range_bad = (tot == '0) || (tot > MAX_IDX) || (idx >= tot);
    assign start_short     = (len_eff < LEN_CAP) && (idx != tot - IDX_W'(1));
    assign recv_range_bad  = (idx >= exp16) || (idx >= MAX_IDX);
    assign recv_short      = (len_eff < LEN_CAP) && (idx != exp16 - IDX_W'(1));

    // bit position inside the row
    assign bit_sel    = idx[ROW_SEL_W-1:0];
    assign bit_onehot = ROW_BITS'(1) << bit_sel;
    assign seen_bit   = row_q[bit_sel];
    assign wr_row     = idx[ROW_SEL_W +: ROW_AW];

    // saturating byte count
    assign bytes_sum   = {1'b0, bytes_reg} + (BYTES_W + 1)'(len_eff);
    assign bytes_added = bytes_sum[BYTES_W] ? BYTES_MAX : bytes_sum[BYTES_W-1:0];

    // decision and next state
    always_comb begin
        receiving_next = receiving_reg;
        cur_msg_next   = cur_msg_reg;
        expected_next  = expected_reg;
        seen_next      = seen_reg;
        bytes_next     = bytes_reg;
        peer_ovr_next  = peer_ovr_reg;
        peer_ip_next   = peer_ip_reg;
        peer_port_next = peer_port_reg;
        action         = ACT_DROP;
        ack_index      = '0;
        done           = 1'b0;
        wr_want        = 1'b0;
        clr_want       = 1'b0;
        wr_data        = bit_onehot;

        if (s1_item_reg.req_type == REQ_CHADDR) begin
            peer_ovr_next  = 1'b1;
            peer_ip_next   = s1_item_reg.src_ip;
            peer_port_next = s1_item_reg.src_port;
            action         = ACT_ACK;
            ack_index      = idx;
        end else if (!cfg_promisc && !from_peer) begin
            action = ACT_DROP;
        end else if (s1_item_reg.req_type == REQ_ACK) begin
            action = ACT_FORWARD;
        end else if (s1_item_reg.req_type == REQ_OTHER) begin
            action = ACT_BAD_TYPE;
        end else if (!receiving_reg) begin
            if (start_range_bad) begin
                action = ACT_RANGE;
            end else if (start_short) begin
                action = ACT_SHORT;
            end else begin
                // first fragment opens a fresh bitmap
                cur_msg_next  = s1_item_reg.message_id;
                expected_next = CNT_W'(tot);
                seen_next     = CNT_W'(1);
                bytes_next    = BYTES_W'(len_eff);
                action        = ACT_ACK;
                ack_index     = idx;
                wr_want       = 1'b1;
                clr_want      = 1'b1;
                wr_data       = bit_onehot;
                if (tot == IDX_W'(1)) begin
                    done = 1'b1;
                end else begin
                    receiving_next = 1'b1;
                end
            end
        end else if (s1_item_reg.message_id != cur_msg_reg) begin
            action = ACT_DROP;
        end else if (recv_range_bad) begin
            action = ACT_RANGE;
        end else if (recv_short) begin
            action = ACT_SHORT;
        end else begin
            // duplicates are acked but not counted
            if (!seen_bit) begin
                seen_next  = seen_reg + CNT_W'(1);
                bytes_next = bytes_added;
                wr_want    = 1'b1;
                wr_data    = row_q | bit_onehot;
            end
            action    = ACT_ACK;
            ack_index = idx;
            if (seen_next >= expected_reg) begin
                done           = 1'b1;
                receiving_next = 1'b0;
            end
        end
    end

    assign bm_cmd.wr  = adv && wr_want;
    assign bm_cmd.clr = adv && clr_want;

    // state update when the header leaves stage one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            receiving_reg <= 1'b0;
            cur_msg_reg   <= '0;
            expected_reg  <= '0;
            seen_reg      <= '0;
            bytes_reg     <= '0;
            peer_ovr_reg  <= 1'b0;
            peer_ip_reg   <= '0;
            peer_port_reg <= '0;
        end else if (adv) begin
            receiving_reg <= receiving_next;
            cur_msg_reg   <= cur_msg_next;
            expected_reg  <= expected_next;
            seen_reg      <= seen_next;
            bytes_reg     <= bytes_next;
            peer_ovr_reg  <= peer_ovr_next;
            peer_ip_reg   <= peer_ip_next;
            peer_port_reg <= peer_port_next;
        end
    end

    // result word
    assign result.action          = action;
    assign result.ack_index       = ack_index;
    assign result.message_done    = done;
    assign result.done_message_id = cur_msg_next;
    assign result.message_bytes   = bytes_next;

endmodule

// ===== test/frt_checker.sv =====
// result checker for the fragment reassembly tracker: header tracking and result compare
module frt_checker
    import frt_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  in_t                   s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  out_t                  m_data,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fails,
    output int                    pending
);

    localparam int MAX_FRAG    = MAX_FRAGMENTS_DEF;
    localparam int BYTES_LIMIT = (1 << BYTES_W) - 1;

    // register copies
    logic              reg_promisc;
    logic [IP_W-1:0]   reg_peer_ip;
    logic [PORT_W-1:0] reg_peer_port;

    // peer set by a change-address packet
    logic              peer_moved;
    logic [IP_W-1:0]   moved_ip;
    logic [PORT_W-1:0] moved_port;

    // reassembly of the message in progress
    logic                busy;
    logic [MID_W-1:0]    cur_mid;
    int                  want;
    int                  got;
    int                  byte_total;
    logic [MAX_FRAG-1:0] seen;

    // results still owed by the block, oldest first
    out_t due_results[$];

    // mark one fragment received, returns 1 once the message is whole
    function automatic logic add_fragment(input int idx, input logic [LEN_W-1:0] len);
        int sum;
        if (!seen[idx]) begin
            seen[idx] = 1'b1;
            got++;
            sum = byte_total + int'(len);
            byte_total = (sum > BYTES_LIMIT) ? BYTES_LIMIT : sum;
        end
        return got >= want;
    endfunction

    // work out the result of one header and advance the tracking state
    task automatic track_header(input in_t h, output out_t r);
        logic [LEN_W-1:0] len;
        logic             from_peer;
        int               idx;
        int               tot;
        r = '0;
        r.action = ACT_DROP;
        len = (h.pay_len > LEN_CAP) ? LEN_CAP : h.pay_len;
        idx = int'(h.fragment_index);
        tot = int'(h.fragment_total);
        if (h.req_type == REQ_CHADDR) begin
            peer_moved  = 1'b1;
            moved_ip    = h.src_ip;
            moved_port  = h.src_port;
            r.action    = ACT_ACK;
            r.ack_index = h.fragment_index;
        end else begin
            from_peer = peer_moved ? (h.src_ip == moved_ip && h.src_port == moved_port)
                                   : (h.src_ip == reg_peer_ip && h.src_port == reg_peer_port);
            if (!reg_promisc && !from_peer) begin
                r.action = ACT_DROP;
            end else if (h.req_type == REQ_ACK) begin
                r.action = ACT_FORWARD;
            end else if (h.req_type == REQ_OTHER) begin
                r.action = ACT_BAD_TYPE;
            end else if (!busy) begin
                // first fragment opens a message
                if (tot == 0 || tot > MAX_FRAG || idx >= tot) begin
                    r.action = ACT_RANGE;
                end else if (len < LEN_CAP && idx != tot - 1) begin
                    r.action = ACT_SHORT;
                end else begin
                    seen       = '0;
                    cur_mid    = h.message_id;
                    want       = tot;
                    got        = 0;
                    byte_total = 0;
                    r.action       = ACT_ACK;
                    r.ack_index    = h.fragment_index;
                    r.message_done = add_fragment(idx, len);
                    busy           = !r.message_done;
                end
            end else if (h.message_id != cur_mid) begin
                r.action = ACT_DROP;
            end else if (idx >= want || idx >= MAX_FRAG) begin
                r.action = ACT_RANGE;
            end else if (len < LEN_CAP && idx != want - 1) begin
                r.action = ACT_SHORT;
            end else begin
                r.action       = ACT_ACK;
                r.ack_index    = h.fragment_index;
                r.message_done = add_fragment(idx, len);
                if (r.message_done) busy = 1'b0;
            end
        end
        r.done_message_id = cur_mid;
        r.message_bytes   = BYTES_W'(byte_total);
    endtask

    // report one differing field, returns 1 on a mismatch
    function automatic int field_bad(input string name, input logic [31:0] exp_v,
                                     input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            return 1;
        end
        return 0;
    endfunction

    // watch the three channels
    always @(posedge aclk) begin
        out_t want_r;
        out_t next_r;
        int   bad;
        if (!aresetn) begin
            reg_promisc   = 1'b0;
            reg_peer_ip   = '0;
            reg_peer_port = '0;
            peer_moved    = 1'b0;
            moved_ip      = '0;
            moved_port    = '0;
            busy          = 1'b0;
            cur_mid       = '0;
            want          = 0;
            got           = 0;
            byte_total    = 0;
            seen          = '0;
            due_results.delete();
        end else begin
            // register writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_PROMISC:   reg_promisc   = cfg_data[0];
                    CFG_PEER_IP:   reg_peer_ip   = cfg_data[IP_W-1:0];
                    CFG_PEER_PORT: reg_peer_port = cfg_data[PORT_W-1:0];
                    default: ;
                endcase
            end
            // result words against the oldest expectation
            if (m_valid && m_ready) begin
                if (due_results.size() == 0) begin
                    $display("%0t: result with nothing expected, actual %p", $time, m_data);
                    fails++;
                end else begin
                    want_r = due_results.pop_front();
                    bad = field_bad("action", 32'(want_r.action), 32'(m_data.action))
                        + field_bad("ack_index", 32'(want_r.ack_index),
                                    32'(m_data.ack_index))
                        + field_bad("message_done", 32'(want_r.message_done),
                                    32'(m_data.message_done))
                        + field_bad("done_message_id", 32'(want_r.done_message_id),
                                    32'(m_data.done_message_id))
                        + field_bad("message_bytes", 32'(want_r.message_bytes),
                                    32'(m_data.message_bytes));
                    if (bad != 0) fails++;
                end
            end
            // header words
            if (s_valid && s_ready) begin
                track_header(s_data, next_r);
                due_results.insert(due_results.size(), next_r);
            end
        end
        pending <= due_results.size();
    end

endmodule

// ===== test/tb_top.sv =====
// testbench top for the fragment reassembly tracker: clock, reset, stimulus and verdict
module tb_top;
    import frt_pkg::*;

    localparam int MAX_FRAG = MAX_FRAGMENTS_DEF;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_t                   s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_t                  m_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fails;
    int                    pending;

    // peer as the block should see it
    logic [IP_W-1:0]   peer_ip;
    logic [PORT_W-1:0] peer_port;

    // message being sent in pieces
    logic [MID_W-1:0]    plan_mid;
    int                  plan_total;
    int                  frag_left;
    logic [MAX_FRAG-1:0] plan_sent;

    int sent_count;
    bit steady;
    bit stall_req;

    fragment_reassembly_tracker dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    frt_checker u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fails     (fails),
        .pending   (pending)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // run limit
    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    function automatic in_t header_of(input req_t t, input logic [IP_W-1:0] ip,
                                      input logic [PORT_W-1:0] port,
                                      input logic [MID_W-1:0] mid,
                                      input logic [IDX_W-1:0] idx,
                                      input logic [IDX_W-1:0] tot,
                                      input logic [LEN_W-1:0] len);
        in_t h;
        h.req_type       = t;
        h.src_ip         = ip;
        h.src_port       = port;
        h.message_id     = mid;
        h.fragment_index = idx;
        h.fragment_total = tot;
        h.pay_len        = len;
        return h;
    endfunction

    // offer one header word and wait until it is taken
    task automatic send_hdr(input in_t h);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= h;
        if (h.req_type == REQ_CHADDR) begin
            peer_ip   = h.src_ip;
            peer_port = h.src_port;
        end
        do @(posedge aclk); while (!s_ready);
        sent_count++;
    endtask

    // stop sending and let every owed result come out
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic set_regs(input logic promisc, input logic [IP_W-1:0] ip,
                            input logic [PORT_W-1:0] port);
        write_reg(CFG_PROMISC, CFG_DATA_W'(promisc));
        write_reg(CFG_PEER_IP, ip);
        write_reg(CFG_PEER_PORT, CFG_DATA_W'(port));
        cfg_valid <= 1'b0;
    endtask

    // mostly fragments of whole messages in random order, the rest broken or noise
    task automatic random_phase(input int n_items, input int wf_pct, input bit big);
        in_t h;
        int  i;
        int  j;
        int  k;
        int  r;
        int  pick;
        if (big) begin
            plan_mid   = MID_W'($urandom);
            plan_total = MAX_FRAG;
            plan_sent  = '0;
            frag_left  = MAX_FRAG;
        end
        for (i = 0; i < n_items; i++) begin
            if (big && frag_left == 0) break;
            // back-to-back stretch, with a long output stall when the large message runs
            if (i == 20 && !big) steady = 1'b1;
            if (i == 45 && !big) steady = 1'b0;
            if (i == 40 && big) begin
                steady    = 1'b1;
                stall_req = 1'b1;
            end
            if (i == 70 && big) steady = 1'b0;
            if (frag_left == 0) begin
                r = $urandom_range(0, 99);
                plan_total = (r < 75) ? $urandom_range(1, 4) :
                             (r < 95) ? $urandom_range(5, 16) : $urandom_range(32, 64);
                plan_mid   = MID_W'($urandom);
                plan_sent  = '0;
                frag_left  = plan_total;
            end
            // noise as the default
            h.req_type       = req_t'($urandom_range(0, 3));
            h.src_ip         = $urandom_range(0, 1) ? peer_ip : IP_W'($urandom);
            h.src_port       = $urandom_range(0, 1) ? peer_port : PORT_W'($urandom);
            h.message_id     = $urandom_range(0, 1) ? plan_mid : MID_W'($urandom);
            h.fragment_index = IDX_W'($urandom);
            h.fragment_total = IDX_W'($urandom);
            h.pay_len        = LEN_W'($urandom_range(0, 2047));
            pick = $urandom_range(0, 99);
            if (pick < wf_pct + 8) begin
                h.req_type   = REQ_DATA;
                h.src_ip     = peer_ip;
                h.src_port   = peer_port;
                h.message_id = plan_mid;
                h.fragment_total = IDX_W'(plan_total);
            end
            if (pick < wf_pct) begin
                // next fragment, unsent ones first with some repeats
                k = $urandom_range(0, plan_total - 1);
                if (plan_sent[k] && $urandom_range(0, 3) != 0) begin
                    for (j = 0; j < plan_total; j++) begin
                        if (!plan_sent[(k + j) % plan_total]) begin
                            k = (k + j) % plan_total;
                            break;
                        end
                    end
                end
                if (!plan_sent[k]) begin
                    plan_sent[k] = 1'b1;
                    frag_left--;
                end
                h.fragment_index = IDX_W'(k);
                if (k == plan_total - 1)
                    h.pay_len = LEN_W'($urandom_range(0, 1024));
                else
                    h.pay_len = ($urandom_range(0, 9) == 0) ? LEN_W'($urandom_range(1025, 2047))
                                                            : LEN_W'(PAYLOAD_BYTES);
                // total is ignored once a message is open
                if (frag_left < plan_total - 1 && $urandom_range(0, 7) == 0)
                    h.fragment_total = IDX_W'($urandom);
            end else if (pick < wf_pct + 8) begin
                // index past the end, or a short piece that is not the last
                if (plan_total == 1 || $urandom_range(0, 1) == 0) begin
                    h.fragment_index = IDX_W'($urandom_range(plan_total, 65535));
                end else begin
                    h.fragment_index = IDX_W'($urandom_range(0, plan_total - 2));
                    h.pay_len        = LEN_W'($urandom_range(0, 1023));
                end
            end else if (pick < wf_pct + 14) begin
                h.req_type = REQ_ACK;
                h.src_ip   = peer_ip;
                h.src_port = peer_port;
            end else if (pick < wf_pct + 17) begin
                h.req_type = REQ_CHADDR;
            end
            send_hdr(h);
            if ($urandom_range(0, 49) == 0) drain();
        end
        // close the message in progress so the next phase starts idle
        for (j = 0; j < plan_total && frag_left > 0; j++) begin
            if (!plan_sent[j]) begin
                plan_sent[j] = 1'b1;
                frag_left--;
                send_hdr(header_of(REQ_DATA, peer_ip, peer_port, plan_mid, IDX_W'(j),
                                   IDX_W'(plan_total),
                                   (j == plan_total - 1) ? LEN_W'(0) : LEN_W'(PAYLOAD_BYTES)));
            end
        end
        steady = 1'b0;
    endtask

    // output side: random idles, stretches with none, one long hold on request
    initial begin : result_side
        int idle_left;
        int hold_left;
        idle_left = 0;
        hold_left = 0;
        m_ready   = 1'b0;
        forever begin
            @(posedge aclk);
            if (stall_req) begin
                stall_req = 1'b0;
                hold_left = 150;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (steady || idle_left == 0) begin
                m_ready <= 1'b1;
                if (!steady && $urandom_range(0, 2) == 0) idle_left = pick_gap();
            end else begin
                idle_left--;
                m_ready <= 1'b0;
            end
        end
    end

    // reset, registers, directed headers, then random phases
    initial begin
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_data     = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        steady     = 1'b0;
        stall_req  = 1'b0;
        sent_count = 0;
        frag_left  = 0;
        plan_total = 1;
        plan_mid   = '0;
        plan_sent  = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_regs(1'b0, '1, '1);
        peer_ip   = '1;
        peer_port = '1;

        // peer filter and non-data types
        send_hdr(header_of(REQ_DATA, '0, '0, 16'd1, 16'd0, 16'd1, 11'd1024));
        send_hdr(header_of(REQ_ACK, '1, '1, 16'd1, 16'd3, 16'd4, 11'd0));
        send_hdr(header_of(REQ_OTHER, '1, '1, 16'd1, 16'd0, 16'd1, 11'd1024));
        // range and short checks while idle
        send_hdr(header_of(REQ_DATA, '1, '1, 16'd2, 16'd0, 16'd0, 11'd1024));
        send_hdr(header_of(REQ_DATA, '1, '1, 16'd2, 16'd0, 16'd257, 11'd1024));
        send_hdr(header_of(REQ_DATA, '1, '1, 16'd2, 16'd300, 16'd256, 11'd1024));
        send_hdr(header_of(REQ_DATA, '1, '1, 16'd2, 16'd0, 16'd3, 11'd100));
        // single-fragment message with empty payload
        send_hdr(header_of(REQ_DATA, '1, '1, 16'hFFFF, 16'd0, 16'd1, 11'd0));
        // three-fragment message, oversize first payload
        send_hdr(header_of(REQ_DATA, '1, '1, 16'd7, 16'd0, 16'd3, 11'd2047));
        send_hdr(header_of(REQ_DATA, '1, '1, 16'd8, 16'd1, 16'd3, 11'd1024));
        send_hdr(header_of(REQ_DATA, '1, '1, 16'd7, 16'd0, 16'd3, 11'd1024));
        send_hdr(header_of(REQ_DATA, '1, '1, 16'd7, 16'd5, 16'd100, 11'd1024));
        send_hdr(header_of(REQ_DATA, '1, '1, 16'd7, 16'hFFFF, 16'hFFFF, 11'd2047));
        send_hdr(header_of(REQ_DATA, '1, '1, 16'd7, 16'd1, 16'd9, 11'd1024));
        send_hdr(header_of(REQ_DATA, '1, '1, 16'd7, 16'd1, 16'd3, 11'd10));
        // peer moves mid-message
        send_hdr(header_of(REQ_CHADDR, 32'h0A00_0002, 16'h1234, 16'd0, 16'hFFFF, 16'd0, 11'd0));
        send_hdr(header_of(REQ_DATA, '1, '1, 16'd7, 16'd2, 16'd3, 11'd5));
        send_hdr(header_of(REQ_DATA, 32'h0A00_0002, 16'h1234, 16'd7, 16'd2, 16'd3, 11'd5));
        // peer moves to the all-zero address, two-fragment message
        send_hdr(header_of(REQ_CHADDR, '0, '0, 16'd0, 16'd0, 16'd0, 11'd0));
        send_hdr(header_of(REQ_DATA, '0, '0, 16'd0, 16'd1, 16'd2, 11'd1024));
        send_hdr(header_of(REQ_DATA, '0, '0, 16'd0, 16'd0, 16'd2, 11'd1024));
        drain();

        set_regs(1'b1, '0, '0);
        random_phase(100, 70, 1'b0);
        drain();

        set_regs(1'b0, IP_W'($urandom), PORT_W'($urandom));
        random_phase(400, 90, 1'b1);
        drain();

        set_regs(1'b1, IP_W'($urandom), PORT_W'($urandom));
        random_phase(110, 65, 1'b0);
        drain();

        $display("covered %0d headers: directed cases, random messages up to %0d fragments",
                 sent_count, MAX_FRAG);
        $display("over four register settings, with random idles and one long output stall");
        if (fails == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
